### rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while the active-low reset is asserted.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    `ASSERT_AT(lbl, clk, rst_n, !(cond), msg)

`endif

### rtl/pcodec_pkg.sv
// Shared types and constants of the percent codec.
`default_nettype none
package pcodec_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [7:0] C_PCT    = 8'h25;
    localparam logic [7:0] C_DASH   = 8'h2D;
    localparam logic [7:0] C_USCORE = 8'h5F;
    localparam logic [7:0] C_DOT    = 8'h2E;
    localparam logic [7:0] C_TILDE  = 8'h7E;
    localparam logic [7:0] C_UA     = 8'h41;
    localparam logic [7:0] C_LA     = 8'h61;
    localparam logic [7:0] C_ZERO   = 8'h30;

    localparam logic [1:0] REG_MODE = 2'd0;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    // One classified input item: up to three output bytes.
    typedef struct packed {
        logic [1:0] cnt;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic       msg_end;
    } t_cmd;

    // Mode and decoder clear from the register port.
    typedef struct packed {
        logic clr;
        logic mode;
    } t_cfg;

endpackage
`default_nettype wire

### rtl/percent_codec_unit.sv
// Top level of the streaming percent codec.
// Percent (URL) encoder and decoder, one message byte per input transfer. Register 0
// (mode, byte address 0) selects encode (0) or decode (1); writing it drops any pending
// escape, and it must be written only while the codec is idle. Output is one byte per
// cycle, while commands are queued and the receiver is ready, from a registered output
// stage. In encode mode an unreserved byte yields one output byte and any other
// byte three ('%' and two uppercase hex digits). In decode mode a completed escape or a
// plain byte yields one byte, and a '%' or the char after it yields none unless it ends
// the message: a message ending right after '%' sends the '%' alone, and one ending one
// char after '%' sends the '%' and that char. A queue of QUEUE_DEPTH commands between
// the input classifier and the output sequencer lets input run ahead of a stalled
// output; input is held off only while that queue is full. m_axis_tuser marks the last
// byte caused by one input byte; m_axis_tlast marks the final byte of the message.
`default_nettype none
`include "assert_macros.svh"
module percent_codec_unit #(
    parameter int QUEUE_DEPTH = pcodec_pkg::QUEUE_DEPTH_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_psel,
    input  wire         i_penable,
    input  wire         i_pwrite,
    input  wire  [2:0]  i_paddr,
    input  wire  [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [7:0]  i_s_axis_tdata,   // [7:0] in_byte
    input  wire         i_s_axis_tlast,   // in_end
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [7:0] out_byte
    output logic        o_m_axis_tuser,   // run_last
    output logic        o_m_axis_tlast    // out_end
);
    import pcodec_pkg::*;

    logic  r_mode;
    logic  w_wr, w_mode_wr;
    t_cfg  w_cfg;
    t_cmd  w_cmd, w_head;
    logic  w_push, w_pop, w_full, w_empty;

    assign o_pready  = 1'b1;
    assign w_wr      = i_psel && i_penable && i_pwrite && o_pready;
    assign w_mode_wr = w_wr && ({1'b0, i_paddr[2]} == REG_MODE);
    assign o_prdata  = ({1'b0, i_paddr[2]} == REG_MODE) ? {31'd0, r_mode} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_ENCODE;
        end else if (w_mode_wr) begin
            r_mode <= i_pwdata[0];
        end
    end

    assign w_cfg.clr  = w_mode_wr;
    assign w_cfg.mode = r_mode;

    pcodec_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_byte   (i_s_axis_tdata),
        .i_end    (i_s_axis_tlast),
        .i_q_full (w_full),
        .o_push   (w_push),
        .o_cmd    (w_cmd)
    );

    pcodec_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    pcodec_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (w_head),
        .i_empty    (w_empty),
        .o_pop      (w_pop),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_byte     (o_m_axis_tdata),
        .o_run_last (o_m_axis_tuser),
        .o_end      (o_m_axis_tlast)
    );

    `ASSERT_NEVER(a_queue_full_empty, i_clk, i_rst_n, w_full && w_empty, "queue full and empty")
    `ASSERT_AT(a_end_is_run_last, i_clk, i_rst_n, (o_m_axis_tvalid && o_m_axis_tlast) |-> o_m_axis_tuser, "message end not on last byte of item")
    `ASSERT_AT(a_encode_escape, i_clk, i_rst_n, (r_mode == MODE_ENCODE && o_m_axis_tvalid && !o_m_axis_tuser) |-> (o_m_axis_tdata == C_PCT || (o_m_axis_tdata >= C_ZERO && o_m_axis_tdata <= C_ZERO + 8'd9) || (o_m_axis_tdata >= C_UA && o_m_axis_tdata <= C_UA + 8'd5)), "bad escape byte in encode mode")

endmodule
`default_nettype wire

### rtl/pcodec_front.sv
// Front end: accepts input bytes, tracks decode state, builds output commands.
`default_nettype none
module pcodec_front (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  pcodec_pkg::t_cfg  i_cfg,
    input  wire               i_valid,
    output logic              o_ready,
    input  wire  [7:0]        i_byte,
    input  wire               i_end,
    input  wire               i_q_full,
    output logic              o_push,
    output pcodec_pkg::t_cmd  o_cmd
);
    import pcodec_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_PCT  = 2'd1,
        PH_HELD = 2'd2
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [7:0] r_held,  n_held;
    t_cmd       w_cmd;
    logic       w_acc;

    function automatic logic is_unreserved(input logic [7:0] c);
        logic r;
        r = (c >= C_ZERO && c <= C_ZERO + 8'd9) ||
            (c >= C_UA && c <= C_UA + 8'd25) ||
            (c >= C_LA && c <= C_LA + 8'd25) ||
            c == C_DASH || c == C_USCORE || c == C_DOT || c == C_TILDE;
        return r;
    endfunction

    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c >= C_ZERO && c <= C_ZERO + 8'd9) begin
            d = c - C_ZERO;
        end else if (c >= C_UA && c <= C_UA + 8'd5) begin
            d = c - C_UA + 8'd10;
        end else if (c >= C_LA && c <= C_LA + 8'd5) begin
            d = c - C_LA + 8'd10;
        end
        return d[3:0];
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        logic [7:0] r;
        r = (n < 4'd10) ? C_ZERO + {4'd0, n} : C_UA + {4'd0, n} - 8'd10;
        return r;
    endfunction

    assign o_ready = !i_q_full;
    assign w_acc   = i_valid && o_ready;

    always_comb begin
        n_phase        = r_phase;
        n_held         = r_held;
        w_cmd.cnt      = 2'd0;
        w_cmd.b0       = i_byte;
        w_cmd.b1       = 8'd0;
        w_cmd.b2       = 8'd0;
        w_cmd.msg_end  = i_end;
        if (i_cfg.mode == MODE_ENCODE) begin
            if (is_unreserved(i_byte)) begin
                w_cmd.cnt = 2'd1;
            end else begin
                w_cmd.cnt = 2'd3;
                w_cmd.b0  = C_PCT;
                w_cmd.b1  = hex_digit(i_byte[7:4]);
                w_cmd.b2  = hex_digit(i_byte[3:0]);
            end
        end else begin
            case (r_phase)
                PH_PCT: begin
                    if (i_end) begin
                        // message ended one char after '%': send both literally
                        w_cmd.cnt = 2'd2;
                        w_cmd.b0  = C_PCT;
                        w_cmd.b1  = i_byte;
                        n_phase   = PH_IDLE;
                        n_held    = 8'd0;
                    end else begin
                        n_held  = i_byte;
                        n_phase = PH_HELD;
                    end
                end
                PH_HELD: begin
                    w_cmd.cnt = 2'd1;
                    w_cmd.b0  = {nibble_of(r_held), nibble_of(i_byte)};
                    n_phase   = PH_IDLE;
                    n_held    = 8'd0;
                end
                default: begin
                    n_phase = PH_IDLE;
                    if (i_byte == C_PCT && !i_end) begin
                        n_phase = PH_PCT;
                    end else begin
                        w_cmd.cnt = 2'd1;
                    end
                end
            endcase
            if (i_end) begin
                n_phase = PH_IDLE;
                n_held  = 8'd0;
            end
        end
    end

    assign o_push = w_acc && (w_cmd.cnt != 2'd0);
    assign o_cmd  = w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg.clr) begin
            r_phase <= PH_IDLE;
            r_held  <= 8'd0;
        end else if (w_acc) begin
            r_phase <= n_phase;
            r_held  <= n_held;
        end
    end

endmodule
`default_nettype wire

### rtl/pcodec_queue.sv
// Command queue between the front end and the output sequencer.
`default_nettype none
module pcodec_queue #(
    parameter int DEPTH = pcodec_pkg::QUEUE_DEPTH_DEF
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  pcodec_pkg::t_cmd  i_cmd,
    input  wire               i_pop,
    output pcodec_pkg::t_cmd  o_head,
    output logic              o_full,
    output logic              o_empty
);
    import pcodec_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             w_push, w_pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        r = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
        return r;
    endfunction

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= ptr_inc(r_wr);
            end
            if (w_pop) begin
                r_rd <= ptr_inc(r_rd);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

### rtl/pcodec_back.sv
// Output sequencer: sends each command's bytes, one transfer per cycle while commands wait and the output is ready.
`default_nettype none
module pcodec_back (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  pcodec_pkg::t_cmd  i_head,
    input  wire               i_empty,
    output logic              o_pop,
    output logic              o_valid,
    input  wire               i_ready,
    output logic [7:0]        o_byte,
    output logic              o_run_last,
    output logic              o_end
);
    import pcodec_pkg::*;

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_run_last, r_end;
    logic [1:0] r_idx;
    logic       w_load, w_fin;
    logic [7:0] w_byte;

    assign w_load = !i_empty && (!r_valid || i_ready);
    assign w_fin  = (r_idx + 2'd1) == i_head.cnt;
    assign o_pop  = w_load && w_fin;

    always_comb begin
        case (r_idx)
            2'd0:    w_byte = i_head.b0;
            2'd1:    w_byte = i_head.b1;
            default: w_byte = i_head.b2;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (w_load) begin
            r_valid <= 1'b1;
            r_idx   <= w_fin ? 2'd0 : r_idx + 2'd1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte     <= w_byte;
            r_run_last <= w_fin;
            r_end      <= w_fin && i_head.msg_end;
        end
    end

    assign o_valid    = r_valid;
    assign o_byte     = r_byte;
    assign o_run_last = r_run_last;
    assign o_end      = r_end;

endmodule
`default_nettype wire
